/* rtl/crle_pkg.sv */
// Shared types and constants for the Catmull-Rom loop evaluator.
package crle_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int ADDR_W         = 10;
    localparam int PC_W           = 7;
    localparam int HW             = 40;
    localparam logic [PC_W-1:0] PC_RESET = 7'd4;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                command;
        logic [5:0]          point_index;
        logic signed [31:0]  coord_x;
        logic signed [31:0]  coord_y;
        logic signed [31:0]  coord_z;
        logic [15:0]         global_t;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  deriv_x;
        logic signed [31:0]  deriv_y;
        logic signed [31:0]  deriv_z;
        logic                overflow;
    } t_out_word;

    typedef struct packed {
        logic                is_eval;
        logic                wr_ok;
        logic [ADDR_W-1:0]   wr_addr;
        logic [95:0]         point;
        logic [15:0]         t;
        logic [ADDR_W-1:0]   idx0;
        logic [ADDR_W-1:0]   idx1;
        logic [ADDR_W-1:0]   idx2;
        logic [ADDR_W-1:0]   idx3;
    } t_qword;

    function automatic logic signed [31:0] sat32(input logic signed [HW-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(HW-32){1'b0}}, 32'h7FFF_FFFF})) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < $signed({{(HW-32){1'b1}}, 32'h8000_0000})) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic is_sat(input logic signed [HW-1:0] x);
        return (x > $signed({{(HW-32){1'b0}}, 32'h7FFF_FFFF})) ||
               (x < $signed({{(HW-32){1'b1}}, 32'h8000_0000}));
    endfunction

endpackage

/* rtl/crle_front.sv */
// Front end: accept words, scale the parameter and resolve the four neighbor slots.
module crle_front #(
    parameter int MAX_POINTS = crle_pkg::MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  crle_pkg::t_in_word         i_word,
    input  logic [crle_pkg::PC_W-1:0]  i_loop_size,
    input  logic                       i_hold,
    output logic                       o_push,
    output crle_pkg::t_qword           o_qword
);
    import crle_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = (AW + 1 > PC_W) ? AW + 1 : PC_W;

    logic [CW-1:0]    loop_n;
    logic             r_valid;
    t_in_word         r_word;
    logic [CW-1:0]    r_n;
    logic [CW+15:0]   r_scaled;
    logic [AW-1:0]    seg, last, i0, i2, i3;
    logic [CW-1:0]    slot;

    // Clamp the loop size to 1..MAX_POINTS.
    always_comb begin
        loop_n = CW'(i_loop_size);
        if (i_loop_size == '0) begin
            loop_n = CW'(1);
        end else if (CW'(i_loop_size) > CW'(MAX_POINTS)) begin
            loop_n = CW'(MAX_POINTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_hold) begin
            r_valid <= i_accept;
        end
        if (i_accept && !i_hold) begin
            r_word   <= i_word;
            r_n      <= loop_n;
            r_scaled <= (CW+16)'(i_word.global_t) * (CW+16)'(loop_n);
        end
    end

    always_comb begin
        seg  = r_scaled[16 +: AW];
        last = AW'(r_n - CW'(1));
        i0   = (seg == '0) ? last : AW'(seg - AW'(1));
        i2   = (seg == last) ? '0 : AW'(seg + AW'(1));
        i3   = (i2 == last) ? '0 : AW'(i2 + AW'(1));
        slot = CW'(r_word.point_index);

        o_push          = r_valid && !i_hold;
        o_qword.is_eval = (r_word.command == CMD_EVAL);
        o_qword.wr_ok   = (slot < CW'(MAX_POINTS));
        o_qword.wr_addr = ADDR_W'(slot);
        o_qword.point   = {r_word.coord_x, r_word.coord_y, r_word.coord_z};
        o_qword.t       = r_scaled[15:0];
        o_qword.idx0    = ADDR_W'(i0);
        o_qword.idx1    = ADDR_W'(seg);
        o_qword.idx2    = ADDR_W'(i2);
        o_qword.idx3    = ADDR_W'(i3);
    end

endmodule

/* rtl/crle_queue.sv */
// Two-entry queue between front and back ends.
module crle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crle_pkg::t_qword  i_qword,
    input  logic              i_pop,
    output logic              o_nonempty,
    output logic              o_full,
    output crle_pkg::t_qword  o_qword
);
    import crle_pkg::*;

    t_qword      r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_nonempty = (r_cnt != 2'd0);
    assign o_full     = (r_cnt == 2'd2);
    assign o_qword    = r_q[r_rp];
    assign do_pop     = i_pop && o_nonempty;
    assign do_push    = i_push && (!o_full || do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) r_q[r_wp] <= i_qword;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");

endmodule

/* rtl/crle_back.sv */
// Back end: point table and pipelined Horner evaluation with saturation.
module crle_back #(
    parameter int MAX_POINTS = crle_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  crle_pkg::t_qword    i_qword,
    output logic                o_strobe,
    output crle_pkg::t_out_word o_result
);
    import crle_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = HW + 17;

    logic [95:0]            r_mem_a [MAX_POINTS];
    logic [95:0]            r_mem_b [MAX_POINTS];
    logic [95:0]            r_rd  [4];
    logic [AW-1:0]          rd_addr [4];
    logic [8:0]             r_v;
    logic [15:0]            r_t [7];
    logic signed [HW-1:0]   r_a3 [3], r_b [3], r_b2 [3], r_c [3], r_d [3];
    logic signed [HW-1:0]   r_c3 [3], r_d2 [3], r_d3 [3], r_d4 [3], r_d5 [3], r_d6 [3];
    logic signed [HW-1:0]   r_c4 [3], r_c5 [3];
    logic signed [PW-1:0]   r_ph [3], r_pg [3];
    logic signed [HW-1:0]   r_h [3], r_g [3];
    logic signed [HW-1:0]   r_h5 [3], r_g5 [3], r_g6 [3], r_h7 [3], r_g7 [3];
    logic signed [PW-1:0]   r_ph6 [3];
    logic signed [HW-1:0]   p [4][3];
    logic signed [PW-1:0]   sh_h [3], sh_g [3], sh_h6 [3], sh_g4 [3], sh_h4 [3];
    logic signed [HW-1:0]   pos [3], drv [3];
    logic signed [31:0]     pos_s [3], drv_s [3];
    logic                   any_sat;
    logic signed [PW-1:0]   r_pg4 [3], r_ph4 [3];

    assign rd_addr[0] = i_qword.idx0[AW-1:0];
    assign rd_addr[1] = i_qword.idx1[AW-1:0];
    assign rd_addr[2] = i_qword.idx2[AW-1:0];
    assign rd_addr[3] = i_qword.idx3[AW-1:0];

    // Two table copies with two read ports each cover the four neighbors.
    always_ff @(posedge i_clk) begin
        if (i_valid && !i_qword.is_eval && i_qword.wr_ok) begin
            r_mem_a[i_qword.wr_addr[AW-1:0]] <= i_qword.point;
            r_mem_b[i_qword.wr_addr[AW-1:0]] <= i_qword.point;
        end
        r_rd[0] <= r_mem_a[rd_addr[0]];
        r_rd[1] <= r_mem_a[rd_addr[1]];
        r_rd[2] <= r_mem_b[rd_addr[2]];
        r_rd[3] <= r_mem_b[rd_addr[3]];
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p[k][0] = HW'($signed(r_rd[k][95:64]));
            p[k][1] = HW'($signed(r_rd[k][63:32]));
            p[k][2] = HW'($signed(r_rd[k][31:0]));
        end
        for (int c = 0; c < 3; c++) begin
            sh_h[c]  = r_ph[c] >>> 16;
            sh_g[c]  = r_pg[c] >>> 16;
            sh_h4[c] = r_ph4[c] >>> 16;
            sh_g4[c] = r_pg4[c] >>> 16;
            sh_h6[c] = r_ph6[c] >>> 16;
            pos[c]   = r_h7[c] >>> 1;
            drv[c]   = r_g7[c] >>> 1;
            pos_s[c] = sat32(pos[c]);
            drv_s[c] = sat32(drv[c]);
        end
        any_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            any_sat = any_sat | is_sat(pos[c]) | is_sat(drv[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[7:0], i_valid && i_qword.is_eval};
        end
        r_t[0] <= i_qword.t;
        for (int s = 1; s < 7; s++) r_t[s] <= r_t[s-1];
        for (int c = 0; c < 3; c++) begin
            // Stage 1: doubled basis coefficients.
            r_a3[c] <= -p[0][c] + 3 * p[1][c] - 3 * p[2][c] + p[3][c];
            r_b[c]  <= 2 * p[0][c] - 5 * p[1][c] + 4 * p[2][c] - p[3][c];
            r_c[c]  <= p[2][c] - p[0][c];
            r_d[c]  <= 2 * p[1][c];
            // Stage 2: first multiply (position and tangent).
            r_ph[c] <= PW'(r_a3[c]) * PW'($signed({1'b0, r_t[1]}));
            r_pg[c] <= PW'(3 * r_a3[c]) * PW'($signed({1'b0, r_t[1]}));
            r_b2[c] <= r_b[c];
            r_c3[c] <= r_c[c];
            r_d2[c] <= r_d[c];
            // Stage 3: add second coefficient.
            r_h[c]  <= $signed(sh_h[c][HW-1:0]) + r_b2[c];
            r_g[c]  <= $signed(sh_g[c][HW-1:0]) + 2 * r_b2[c];
            r_c4[c] <= r_c3[c];
            r_d3[c] <= r_d2[c];
            // Stage 4: second multiply.
            r_ph4[c] <= PW'(r_h[c]) * PW'($signed({1'b0, r_t[3]}));
            r_pg4[c] <= PW'(r_g[c]) * PW'($signed({1'b0, r_t[3]}));
            r_c5[c]  <= r_c4[c];
            r_d4[c]  <= r_d3[c];
            // Stage 5: add C; tangent is finished here.
            r_h5[c] <= $signed(sh_h4[c][HW-1:0]) + r_c5[c];
            r_g5[c] <= $signed(sh_g4[c][HW-1:0]) + r_c5[c];
            r_d5[c] <= r_d4[c];
            // Stage 6: third multiply on position.
            r_ph6[c] <= PW'(r_h5[c]) * PW'($signed({1'b0, r_t[5]}));
            r_g6[c]  <= r_g5[c];
            r_d6[c]  <= r_d5[c];
            // Stage 7: add D.
            r_h7[c] <= $signed(sh_h6[c][HW-1:0]) + r_d6[c];
            r_g7[c] <= r_g6[c];
        end
        // Stage 8: halve, saturate and register the result word.
        o_result.pos_x    <= pos_s[0];
        o_result.pos_y    <= pos_s[1];
        o_result.pos_z    <= pos_s[2];
        o_result.deriv_x  <= drv_s[0];
        o_result.deriv_y  <= drv_s[1];
        o_result.deriv_z  <= drv_s[2];
        o_result.overflow <= any_sat;
    end

    assign o_strobe = r_v[8];

    a_ovf_means_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.overflow) |->
            (o_result.pos_x == 32'sh7FFF_FFFF || o_result.pos_x == 32'sh8000_0000 ||
             o_result.pos_y == 32'sh7FFF_FFFF || o_result.pos_y == 32'sh8000_0000 ||
             o_result.pos_z == 32'sh7FFF_FFFF || o_result.pos_z == 32'sh8000_0000 ||
             o_result.deriv_x == 32'sh7FFF_FFFF || o_result.deriv_x == 32'sh8000_0000 ||
             o_result.deriv_y == 32'sh7FFF_FFFF || o_result.deriv_y == 32'sh8000_0000 ||
             o_result.deriv_z == 32'sh7FFF_FFFF || o_result.deriv_z == 32'sh8000_0000))
        else $error("overflow flag without a saturated component");
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_qword.is_eval) |=> !r_v[0])
        else $error("load word entered the evaluation pipeline");

endmodule

/* rtl/catmull_rom_loop_evaluator_top.sv */
// Top level of the closed-loop Catmull-Rom spline evaluator.
// Usage:
//   Input channel: drive i_word and raise start; the word is taken at a rising
//   edge where start is high and busy is low. command LOAD writes a control
//   point into slot point_index; command EVAL samples the loop at global_t.
//   Configuration: i_cfg_we with i_cfg_wdata writes the loop size,
//   reset value 4; write it only while no evaluation is in flight.
//   Result channel: o_strobe is high for exactly one cycle with o_result
//   holding position, tangent and the overflow flag. The receiver cannot
//   stall, so results are never held back.
//   Path: an EVAL word passes the front register, the queue, the table read,
//   seven arithmetic stages and the output register before its result
//   appears on o_result. Loads give no result.
//   Throughput: one word per cycle; the back end drains the queue every
//   cycle, so busy stays low in normal use.
//   Reset (synchronous, active low) clears the pipeline and the queue and
//   restores the loop size; the point table holds garbage until loaded.
module catmull_rom_loop_evaluator_top #(
    parameter int MAX_POINTS = crle_pkg::MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  crle_pkg::t_in_word         i_word,
    input  logic                       i_cfg_we,
    input  logic [crle_pkg::PC_W-1:0]  i_cfg_wdata,
    output logic                       o_strobe,
    output crle_pkg::t_out_word        o_result
);
    import crle_pkg::*;

    logic [PC_W-1:0] r_loop_size;
    logic            push, q_nonempty, q_full, hold;
    t_qword          f_qword, q_qword;

    // Hold the loop size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_size <= PC_RESET;
        end else if (i_cfg_we) begin
            r_loop_size <= i_cfg_wdata;
        end
    end

    // The back end pops every cycle, so the queue only fills if it cannot drain.
    assign hold = q_full && !q_nonempty;
    assign busy = hold;

    crle_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start && !busy),
        .i_word        (i_word),
        .i_loop_size   (r_loop_size),
        .i_hold        (hold),
        .o_push        (push),
        .o_qword       (f_qword)
    );

    crle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_qword    (f_qword),
        .i_pop      (q_nonempty),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_qword    (q_qword)
    );

    crle_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_nonempty),
        .i_qword  (q_qword),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
